// File: rtl/core/hpm_pkg.sv
// Package with the types and constants shared by the homography point mapper.
package hpm_pkg;

  localparam int NUM_COEFS = 8;
  localparam int COEF_W    = 48;
  localparam int CIDX_W    = 4;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 80;
  localparam int SUM_W     = 82;
  localparam int NUM_W     = 99;
  localparam int QUO_W     = 33;
  localparam int DIV_STEPS = 33;

  localparam logic [COEF_W-1:0] COEF_ONE = 48'h0001_0000_0000;

  // Register indexes of the coefficient file.
  localparam logic [CIDX_W-1:0] IDX_H00 = 4'd0;
  localparam logic [CIDX_W-1:0] IDX_H01 = 4'd1;
  localparam logic [CIDX_W-1:0] IDX_H02 = 4'd2;
  localparam logic [CIDX_W-1:0] IDX_H10 = 4'd3;
  localparam logic [CIDX_W-1:0] IDX_H11 = 4'd4;
  localparam logic [CIDX_W-1:0] IDX_H12 = 4'd5;
  localparam logic [CIDX_W-1:0] IDX_H20 = 4'd6;
  localparam logic [CIDX_W-1:0] IDX_H21 = 4'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mapped_x;
    logic signed [COORD_W-1:0] mapped_y;
    logic                      invalid;
  } result_t;

  // One lane of the divider pipeline.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [SUM_W-1:0] den;
    div_lane_t        lx;
    div_lane_t        ly;
  } div_stage_t;

endpackage

// File: rtl/core/homography_point_map.sv
// Top level of the planar homography point mapper.
// Maps one signed Q16.16 point through a 3x3 homography with h22 fixed at 1.
// A point can be started in every clock cycle; busy never rises. Each
// transaction yields one result, shown on result for exactly one cycle with
// done high. The pipeline has one input register loaded at the accepting
// edge, partial-product and full-product registers of split 24x32
// multiplies, a summing register, a magnitude and range-check register, a
// fully pipelined restoring divider (one quotient bit per stage) and one
// rounding and saturating output register.
// The receiver cannot stall the pipeline, so results must be taken as they
// come. Coefficients are signed Q16.32, reset to identity, and must only be
// written while no transaction is in flight; writes to indexes above seven
// are ignored. A zero denominator sets invalid and zeroes both coordinates.
module homography_point_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  hpm_pkg::point_t               point,
  input  logic                          cfg_we,
  input  logic [hpm_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [hpm_pkg::COEF_W-1:0]    cfg_data,
  output logic                          done,
  output hpm_pkg::result_t              result
);
  import hpm_pkg::*;

  logic [COEF_W-1:0] coef [NUM_COEFS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef[i] <= ((i == int'(IDX_H00)) || (i == int'(IDX_H11))) ? COEF_ONE : '0;
      end
    end else if (cfg_we && (cfg_index < CIDX_W'(NUM_COEFS))) begin
      coef[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // Input register.
  logic               v0;
  point_t             pt0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start;
    pt0 <= point;
  end

  // Partial products: each 48-bit coefficient is split into a signed upper
  // and an unsigned lower 24-bit half. Product j uses coefficient
  // h00, h01, h10, h11, h20, h21 and multiplies x for even j, y for odd j.
  localparam int NPROD = 6;

  function automatic int prod_coef(input int j);
    return (j / 2) * 3 + (j % 2);
  endfunction

  logic               v1;
  logic signed [55:0] ph [NPROD];
  logic signed [56:0] pl [NPROD];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    for (int j = 0; j < NPROD; j++) begin
      ph[j] <= $signed(coef[prod_coef(j)][47:24]) *
               $signed((j % 2 == 0) ? pt0.point_x : pt0.point_y);
      pl[j] <= $signed({1'b0, coef[prod_coef(j)][23:0]}) *
               $signed((j % 2 == 0) ? pt0.point_x : pt0.point_y);
    end
  end

  // Full 80-bit products.
  logic                     v2;
  logic signed [PROD_W-1:0] prod [NPROD];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    for (int j = 0; j < NPROD; j++) begin
      prod[j] <= $signed({ph[j], 24'b0}) + $signed({{23{pl[j][56]}}, pl[j]});
    end
  end

  // Numerators and denominator, all exact in Q.48.
  logic                    v3;
  logic signed [SUM_W-1:0] nx, ny, wd;

  function automatic logic signed [SUM_W-1:0] ext_p(input logic signed [PROD_W-1:0] p);
    return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_c(input logic [COEF_W-1:0] c);
    return {{(SUM_W-COEF_W-16){c[COEF_W-1]}}, c, 16'b0};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    nx <= ext_p(prod[0]) + ext_p(prod[1]) + ext_c(coef[IDX_H02[2:0]]);
    ny <= ext_p(prod[2]) + ext_p(prod[3]) + ext_c(coef[IDX_H12[2:0]]);
    wd <= ext_p(prod[4]) + ext_p(prod[5]) + (SUM_W'(1) << 48);
  end

  // Magnitudes; dividend carries the Q16 scale plus one extra bit so the
  // divider yields twice the quotient and the rounding bit falls out of it.
  div_stage_t dv [DIV_STEPS+1];
  logic [SUM_W-1:0] mag_x, mag_y, mag_w;
  logic [NUM_W-1:0] n2x, n2y;

  always_comb begin
    mag_x = nx[SUM_W-1] ? SUM_W'(-nx) : nx;
    mag_y = ny[SUM_W-1] ? SUM_W'(-ny) : ny;
    mag_w = wd[SUM_W-1] ? SUM_W'(-wd) : wd;
    n2x   = {mag_x, 17'b0};
    n2y   = {mag_y, 17'b0};
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  function automatic div_lane_t div_step(input div_lane_t l, input logic [SUM_W-1:0] d,
                                         input int k);
    div_lane_t  o;
    logic [NUM_W-1:0] dext;
    o    = l;
    dext = {{(NUM_W-SUM_W){1'b0}}, d};
    if ((l.rem >> k) >= dext) begin
      o.rem = l.rem - (dext << k);
      o.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) dv[0].valid <= 1'b0;
    else dv[0].valid <= v3;
    dv[0].zero   <= (wd == '0);
    dv[0].den    <= mag_w;
    dv[0].lx.rem <= n2x;
    dv[0].ly.rem <= n2y;
    dv[0].lx.quo <= '0;
    dv[0].ly.quo <= '0;
    dv[0].lx.neg <= nx[SUM_W-1] ^ wd[SUM_W-1];
    dv[0].ly.neg <= ny[SUM_W-1] ^ wd[SUM_W-1];
    // A doubled quotient of 2^33 or more saturates either way.
    dv[0].lx.ovf <= ({16'b0, n2x[NUM_W-1:QUO_W]} >= mag_w);
    dv[0].ly.ovf <= ({16'b0, n2y[NUM_W-1:QUO_W]} >= mag_w);
    for (int s = 1; s <= DIV_STEPS; s++) begin
      if (rst) dv[s].valid <= 1'b0;
      else dv[s].valid <= dv[s-1].valid;
      dv[s].zero <= dv[s-1].zero;
      dv[s].den  <= dv[s-1].den;
      dv[s].lx   <= div_step(dv[s-1].lx, dv[s-1].den, DIV_STEPS - s);
      dv[s].ly   <= div_step(dv[s-1].ly, dv[s-1].den, DIV_STEPS - s);
    end
  end

  // Round half away from zero, saturate, apply sign.
  function automatic logic [COORD_W-1:0] finish(input div_lane_t l);
    logic [QUO_W:0] qr;
    qr = ({1'b0, l.quo} + (QUO_W+1)'(1)) >> 1;
    if (l.neg) begin
      if (l.ovf || (qr > (QUO_W+1)'(34'h0_8000_0000))) return 32'h8000_0000;
      return COORD_W'(-qr);
    end
    if (l.ovf || (qr > (QUO_W+1)'(34'h0_7FFF_FFFF))) return 32'h7FFF_FFFF;
    return qr[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv[DIV_STEPS].valid;
    if (dv[DIV_STEPS].zero) begin
      result.mapped_x <= '0;
      result.mapped_y <= '0;
      result.invalid  <= 1'b1;
    end else begin
      result.mapped_x <= finish(dv[DIV_STEPS].lx);
      result.mapped_y <= finish(dv[DIV_STEPS].ly);
      result.invalid  <= 1'b0;
    end
  end

endmodule

// File: verif/homography_point_map_tb.sv
// Self-checking testbench for the planar homography point mapper.
`timescale 1ns / 100ps

module homography_point_map_tb;
  import hpm_pkg::*;

  localparam int N_RANDOM   = 1750;
  localparam int MAX_REPORT = 10;
  localparam int SETTLE     = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  point_t point = '0;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  logic done;
  result_t result;

  homography_point_map dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The predictor keeps its own copy of the coefficient file. Each accepted
  // transaction pushes one expected result that the monitor pops on done.
  logic signed [COEF_W-1:0] coef_file [NUM_COEFS];
  result_t mapped_queue [$];
  int mismatches = 0;
  int reported = 0;
  bit idle_gaps = 1'b1;

  // Rounded, saturated quotient of num * 2^16 / den in Q16.16. The division
  // is carried out on magnitudes so that an exact half rounds away from zero.
  function automatic logic [31:0] div_round_sat(logic signed [SUM_W-1:0] num,
                                                logic signed [SUM_W-1:0] den);
    logic neg;
    logic [127:0] a, b, q, r;
    neg = num[SUM_W-1] ^ den[SUM_W-1];
    a = num[SUM_W-1] ? 128'(-num) : 128'(num);
    b = den[SUM_W-1] ? 128'(-den) : 128'(den);
    a = a << 16;
    q = a / b;
    r = a % b;
    if ((r << 1) >= b) q = q + 1;
    if (neg) return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  // Maps one point through the current matrix. Sums are exact in 82 bits.
  function automatic result_t map_point(point_t p);
    logic signed [SUM_W-1:0] nx, ny, w;
    logic signed [SUM_W-1:0] px, py;
    result_t r;
    px = SUM_W'(p.point_x);
    py = SUM_W'(p.point_y);
    nx = SUM_W'(coef_file[IDX_H00[2:0]]) * px + SUM_W'(coef_file[IDX_H01[2:0]]) * py
       + (SUM_W'(coef_file[IDX_H02[2:0]]) <<< 16);
    ny = SUM_W'(coef_file[IDX_H10[2:0]]) * px + SUM_W'(coef_file[IDX_H11[2:0]]) * py
       + (SUM_W'(coef_file[IDX_H12[2:0]]) <<< 16);
    w  = SUM_W'(coef_file[IDX_H20[2:0]]) * px + SUM_W'(coef_file[IDX_H21[2:0]]) * py
       + (SUM_W'(1) <<< 48);
    r = '0;
    if (w == 0) begin
      r.invalid = 1'b1;
    end else begin
      r.mapped_x = div_round_sat(nx, w);
      r.mapped_y = div_round_sat(ny, w);
    end
    return r;
  endfunction

  // Writes one coefficient register; only called while the block is idle.
  task automatic write_coef(logic [CIDX_W-1:0] idx, logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx < NUM_COEFS) coef_file[idx[2:0]] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads all eight coefficients from one array.
  task automatic load_matrix(logic [COEF_W-1:0] m [NUM_COEFS]);
    for (int i = 0; i < NUM_COEFS; i++) write_coef(CIDX_W'(i), m[i]);
  endtask

  // Presents one point and holds start until the transaction is accepted.
  // Start stays high across back-to-back transactions so it is never lowered
  // and raised within the same time step.
  task automatic send_point(point_t p, bit has_expect, result_t want);
    int gap;
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    point <= p;
    do @(posedge clk); while (busy);
    mapped_queue.push_back(has_expect ? want : map_point(p));
  endtask

  // Start drops right after the last accepting edge so no extra point enters.
  task automatic drain;
    start <= 1'b0;
    while (mapped_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Result monitor: done marks a one-cycle result that cannot be held off.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (mapped_queue.size() == 0) begin
        mismatches++;
        if (reported < MAX_REPORT) begin
          reported++;
          $display("unexpected result %h", result);
        end
      end else begin
        result_t want;
        want = mapped_queue.pop_front();
        if (result.mapped_x !== want.mapped_x || result.mapped_y !== want.mapped_y ||
            result.invalid !== want.invalid) begin
          mismatches++;
          if (reported < MAX_REPORT) begin
            reported++;
            $display("mismatch: expected x=%h y=%h inv=%b, got x=%h y=%h inv=%b",
                     want.mapped_x, want.mapped_y, want.invalid,
                     result.mapped_x, result.mapped_y, result.invalid);
          end
        end
      end
    end
  end

  typedef struct {
    point_t  p;
    bit      typed;
    result_t want;
  } dir_row_t;

  function automatic logic [COEF_W-1:0] rand_coef(int mode);
    logic [COEF_W-1:0] v;
    v = COEF_W'({$urandom(), $urandom()});
    case (mode)
      0: v = {{14{v[33]}}, v[33:0]};                       // modest Q16.32 values
      1: v = {{24{v[23]}}, v[23:0]};                       // small perspective terms
      default: ;                                            // full range
    endcase
    return v;
  endfunction

  function automatic point_t rand_point();
    point_t p;
    case ($urandom_range(0, 4))
      0: p = {$urandom(), $urandom()};
      1: p = {32'($signed(20'($urandom()))), 32'($signed(20'($urandom())))};
      2: p = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF, $urandom()};
      default: p = {32'($signed(26'($urandom()))), 32'($signed(26'($urandom())))};
    endcase
    return p;
  endfunction

  initial begin
    dir_row_t rows [$];
    logic [COEF_W-1:0] m [NUM_COEFS];
    result_t nores;
    point_t p;
    nores = '0;

    coef_file[0] = COEF_ONE; coef_file[1] = '0; coef_file[2] = '0; coef_file[3] = '0;
    coef_file[4] = COEF_ONE; coef_file[5] = '0; coef_file[6] = '0; coef_file[7] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Identity after reset: extremes of both coordinates map to themselves.
    rows.push_back('{'{32'h8000_0000, 32'h7FFF_FFFF}, 1,
                     '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}});
    rows.push_back('{'{32'h0000_0000, 32'hFFFF_FFFF}, 1,
                     '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0}});
    rows.push_back('{'{32'h0001_8000, 32'hFFFE_8000}, 1,
                     '{32'h0001_8000, 32'hFFFE_8000, 1'b0}});
    foreach (rows[i]) send_point(rows[i].p, rows[i].typed, rows[i].want);
    drain();

    // A write to an index past the file is ignored.
    write_coef(4'd9, 48'h7FFF_FFFF_FFFF);
    write_coef(4'd15, 48'h8000_0000_0000);

    // Perspective term -1.0 on x: w is zero at x = 1.0, so invalid is flagged.
    write_coef(IDX_H20, -48'sh1_0000_0000);
    write_coef(IDX_H02, 48'h7FFF_FFFF_FFFF);
    write_coef(IDX_H12, 48'h8000_0000_0000);
    rows.delete();
    rows.push_back('{'{32'h0001_0000, 32'h1234_5678}, 1, '{32'h0, 32'h0, 1'b1}});
    rows.push_back('{'{32'h0000_0000, 32'h0000_0000}, 1,
                     '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}});   // saturation
    rows.push_back('{'{32'h0000_8000, 32'h0}, 0, nores});       // w = 0.5
    rows.push_back('{'{32'h0001_0001, 32'h0}, 0, nores});       // tiny negative w
    rows.push_back('{'{32'h8000_0000, 32'h7FFF_FFFF}, 0, nores});
    foreach (rows[i]) send_point(rows[i].p, rows[i].typed, rows[i].want);
    drain();

    // Exact halves: coefficients of 0.5 and -0.5 map odd inputs of 1 and 3 LSB to 0.5 and 1.5 LSB.
    m = '{48'h0000_8000_0000, 48'h0000_8000_0000, 48'h0, 48'hFFFF_8000_0000,
          48'h0, 48'h0, 48'h0, 48'h0};
    load_matrix(m);
    rows.delete();
    rows.push_back('{'{32'h0000_0001, 32'h0000_0000}, 0, nores});
    rows.push_back('{'{32'h0000_0003, 32'h0000_0000}, 0, nores});
    rows.push_back('{'{32'hFFFF_FFFF, 32'h0000_0000}, 0, nores});
    rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, nores});
    rows.push_back('{'{32'h8000_0000, 32'h8000_0000}, 0, nores});
    foreach (rows[i]) send_point(rows[i].p, rows[i].typed, rows[i].want);
    drain();

    // Extreme coefficient values in every register.
    m = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
          48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
          48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000};
    load_matrix(m);
    for (int i = 0; i < 6; i++) send_point(rand_point(), 0, nores);
    drain();

    // Random phases: a fresh matrix every phase, then a run of points.
    for (int ph = 0; ph < 14; ph++) begin
      for (int i = 0; i < NUM_COEFS; i++)
        m[i] = rand_coef(i >= 6 ? ($urandom_range(0, 3) == 0 ? 2 : 1)
                                : $urandom_range(0, 2));
      if (ph % 5 == 4) begin
        m[IDX_H21[2:0]] = '0;
        m[IDX_H20[2:0]] = -48'sh1_0000_0000;   // revisit the zero-denominator line
      end
      load_matrix(m);
      idle_gaps = (ph < 11);
      for (int i = 0; i < N_RANDOM / 14; i++) begin
        p = rand_point();
        if (ph % 5 == 4 && $urandom_range(0, 7) == 0) p.point_x = 32'h0001_0000;
        send_point(p, 0, nores);
      end
      drain();
    end

    if (mismatches == 0 && mapped_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
